### rtl/core/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types and constants for the running-median block: sample widths,
// the chain operation codes, the chain control bundle and the sequencer states.
// ----------------------------------------------------------------------------
package rmth_pkg;

  // Default number of samples the block can hold
  localparam int unsigned CAPACITY_DEF = 1024;

  // Fixed field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEDIAN_W = SAMPLE_W + 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  // Operation applied to every cell of a chain at once
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } chain_op_t;

  // Control bundle from the sequencer to one chain
  typedef struct packed {
    chain_op_t op;
    sample_t   data;
  } chain_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_BALANCE,
    ST_REPORT
  } rmth_state_t;

endpackage

### rtl/core/rmth_cell.sv
// ----------------------------------------------------------------------------
// rmth_cell
// One storage cell of a sorted priority chain. On a push it keeps its value,
// takes the new sample, or takes its left neighbour's value; on a pop it takes
// its right neighbour's value.
// ----------------------------------------------------------------------------
module rmth_cell #(
  parameter bit IS_MAX = 1'b1
) (
  input  logic                clk,
  input  rmth_pkg::chain_op_t op,
  input  rmth_pkg::sample_t   push_val,
  input  logic                own_valid,
  input  rmth_pkg::sample_t   prev_val,
  input  logic                prev_keep,
  input  rmth_pkg::sample_t   next_val,
  output rmth_pkg::sample_t   val,
  output logic                keep
);
  import rmth_pkg::*;

  sample_t val_r;
  sample_t val_nxt;
  logic    ranks;

  // Stay in place when valid and at or above the incoming one (at or below in a min chain)
  assign ranks = IS_MAX ? (val_r >= push_val) : (val_r <= push_val);
  assign keep  = own_valid && ranks;
  assign val   = val_r;

  // Select the next held value
  always_comb begin
    case (op)
      OP_PUSH: begin
        if (keep) begin
          val_nxt = val_r;
        end else if (prev_keep) begin
          val_nxt = push_val;
        end else begin
          val_nxt = prev_val;
        end
      end
      OP_POP:  val_nxt = next_val;
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### rtl/core/rmth_chain.sv
// ----------------------------------------------------------------------------
// rmth_chain
// Sorted row of cells acting as a priority queue: cell 0 holds the top.
// A push inserts in sorted place, a pop shifts everything one cell towards the top.
// ----------------------------------------------------------------------------
module rmth_chain #(
  parameter int unsigned DEPTH  = 513,
  parameter bit          IS_MAX = 1'b1,
  parameter int unsigned CW     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmth_pkg::chain_ctrl_t ctrl,
  output rmth_pkg::sample_t     top,
  output logic [CW-1:0]         count
);
  import rmth_pkg::*;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  sample_t       vals  [DEPTH];
  logic          keeps [DEPTH];

  // Build the row; cell 0 sees the new sample as its left neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sample_t prev_v;
    sample_t next_v;
    logic    prev_k;
    logic    own_v;

    if (i == 0) begin : g_first
      assign prev_v = ctrl.data;
      assign prev_k = 1'b0;
    end else begin : g_rest
      assign prev_v = vals[i-1];
      assign prev_k = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = vals[i];
    end else begin : g_inner
      assign next_v = vals[i+1];
    end

    assign own_v = (CW'(i) < count_r);

    rmth_cell #(
      .IS_MAX (IS_MAX)
    ) u_cell (
      .clk       (clk),
      .op        (ctrl.op),
      .push_val  (ctrl.data),
      .own_valid (own_v),
      .prev_val  (prev_v),
      .prev_keep (prev_k),
      .next_val  (next_v),
      .val       (vals[i]),
      .keep      (keeps[i])
    );
  end

  // Track the fill level
  always_comb begin
    case (ctrl.op)
      OP_PUSH: count_nxt = count_r + CW'(1);
      OP_POP:  count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top   = vals[0];
  assign count = count_r;

endmodule

### rtl/core/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps
// Running median over up to CAPACITY signed samples, kept as a lower and an
// upper sorted chain of cells whose tops give twice the median.
// ----------------------------------------------------------------------------
// Usage: raise start with in_sample while busy is low; the sample is taken at
// that edge and busy stays high until the result has gone out. A stored sample
// is inserted into the lower or upper chain, then a top is moved across if the
// halves differ by two, then out_valid goes high carrying the result, and then
// the block is back in idle, the only state where the next sample is taken.
// When CAPACITY samples are already held the sample is dropped, flagged on
// out_dropped, and the result is out in the cycle right after the transfer,
// skipping insertion and balancing. out_valid is high for exactly one cycle
// per sample and the receiver cannot hold it off, so it must capture the
// result in that cycle. out_median_doubled is twice the median, exact;
// out_sample_count is the number of samples held afterwards.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
  parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  rmth_pkg::sample_t       in_sample,
  output logic                    out_valid,
  output rmth_pkg::median_t       out_median_doubled,
  output logic [CNT_W-1:0]        out_sample_count,
  output logic                    out_dropped
);
  import rmth_pkg::*;

  localparam int unsigned SIDE_DEPTH = CAPACITY / 2 + 1;
  localparam int unsigned SIDE_CW    = $clog2(SIDE_DEPTH + 1);

  rmth_state_t       state_r;
  rmth_state_t       state_nxt;
  sample_t           sample_r;
  logic              dropped_r;
  logic              dropped_nxt;
  chain_ctrl_t       lo_ctrl;
  chain_ctrl_t       up_ctrl;
  sample_t           lo_top;
  sample_t           up_top;
  logic [SIDE_CW-1:0] lo_cnt;
  logic [SIDE_CW-1:0] up_cnt;
  logic [CNT_W-1:0]  total;
  logic              full;
  logic              to_lower;
  logic              lo_heavy;
  logic              up_heavy;
  logic              accept;

  assign total    = CNT_W'(lo_cnt) + CNT_W'(up_cnt);
  assign full     = (total >= CNT_W'(CAPACITY));
  assign to_lower = (lo_cnt == '0) || (sample_r <= lo_top);
  assign lo_heavy = ({1'b0, lo_cnt} > ({1'b0, up_cnt} + (SIDE_CW+1)'(1)));
  assign up_heavy = ({1'b0, up_cnt} > ({1'b0, lo_cnt} + (SIDE_CW+1)'(1)));
  assign accept   = start && !busy;

  // Lower half: largest at the top
  rmth_chain #(
    .DEPTH  (SIDE_DEPTH),
    .IS_MAX (1'b1),
    .CW     (SIDE_CW)
  ) u_lower (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lo_ctrl),
    .top   (lo_top),
    .count (lo_cnt)
  );

  // Upper half: smallest at the top
  rmth_chain #(
    .DEPTH  (SIDE_DEPTH),
    .IS_MAX (1'b0),
    .CW     (SIDE_CW)
  ) u_upper (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (up_ctrl),
    .top   (up_top),
    .count (up_cnt)
  );

  // Next state
  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          dropped_nxt = full;
          state_nxt   = full ? ST_REPORT : ST_INSERT;
        end
      end
      ST_INSERT:  state_nxt = ST_BALANCE;
      ST_BALANCE: state_nxt = ST_REPORT;
      ST_REPORT:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Chain controls and handshake outputs
  always_comb begin
    lo_ctrl   = '{op: OP_HOLD, data: sample_r};
    up_ctrl   = '{op: OP_HOLD, data: sample_r};
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_INSERT: begin
        if (to_lower) begin
          lo_ctrl.op = OP_PUSH;
        end else begin
          up_ctrl.op = OP_PUSH;
        end
      end
      ST_BALANCE: begin
        if (lo_heavy) begin
          lo_ctrl.op   = OP_POP;
          up_ctrl.op   = OP_PUSH;
          up_ctrl.data = lo_top;
        end else if (up_heavy) begin
          up_ctrl.op   = OP_POP;
          lo_ctrl.op   = OP_PUSH;
          lo_ctrl.data = up_top;
        end
      end
      ST_REPORT: out_valid = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  // Median from the two tops
  always_comb begin
    if (lo_cnt == up_cnt) begin
      out_median_doubled = MEDIAN_W'(lo_top) + MEDIAN_W'(up_top);
    end else if (lo_cnt > up_cnt) begin
      out_median_doubled = {lo_top, 1'b0};
    end else begin
      out_median_doubled = {up_top, 1'b0};
    end
  end

  assign out_sample_count = total;
  assign out_dropped      = dropped_r;

  // Hold the sample on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Halves never differ by more than one when a result goes out
  a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, lo_cnt} <= ({1'b0, up_cnt} + (SIDE_CW+1)'(1))) &&
                   ({1'b0, up_cnt} <= ({1'b0, lo_cnt} + (SIDE_CW+1)'(1)))))
    else $error("chain counts out of balance at result");

  // Every lower value sits at or below every upper value
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (lo_cnt != '0) && (up_cnt != '0)) |-> (lo_top <= up_top))
    else $error("lower top above upper top");

  // A drop only happens on a full store
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (total == CNT_W'(CAPACITY)))
    else $error("sample dropped below capacity");

  // The result strobe lasts one cycle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule
